// ----- hw/rtl/pru_pkg.sv -----
// Shared types, constants and a helper function for the PNG row unfilter block.
package pru_pkg;

    localparam int BYTE_W           = 8;
    localparam int ROW_LEN_W        = 13;
    localparam int BPP_W            = 4;
    localparam int FLT_W            = 3;
    localparam int APB_DW           = 32;
    localparam int CFG_AW           = 3;
    localparam int DEF_MAX_ROW_BYTES = 4096;
    localparam int DEF_MAX_BPP      = 8;

    // filter type codes
    localparam logic [FLT_W-1:0] FLT_NONE  = 3'd0;
    localparam logic [FLT_W-1:0] FLT_SUB   = 3'd1;
    localparam logic [FLT_W-1:0] FLT_UP    = 3'd2;
    localparam logic [FLT_W-1:0] FLT_AVG   = 3'd3;
    localparam logic [FLT_W-1:0] FLT_PAETH = 3'd4;

    // register indexes
    localparam logic REG_ROW_LENGTH = 1'b0;
    localparam logic REG_BPP        = 1'b1;

    typedef struct packed {
        logic [ROW_LEN_W-1:0] row_length;
        logic [BPP_W-1:0]     bytes_per_pixel;
    } t_cfg;

    function automatic logic [BYTE_W-1:0] paeth_pred(
        input logic [BYTE_W-1:0] a,
        input logic [BYTE_W-1:0] b,
        input logic [BYTE_W-1:0] c
    );
        logic signed [10:0] sa;
        logic signed [10:0] sb;
        logic signed [10:0] sc;
        logic signed [10:0] da;
        logic signed [10:0] db;
        logic signed [10:0] dc;
        logic [10:0] pa;
        logic [10:0] pb;
        logic [10:0] pc;
        sa = signed'({3'b000, a});
        sb = signed'({3'b000, b});
        sc = signed'({3'b000, c});
        da = sb - sc;
        db = sa - sc;
        dc = sa + sb - (sc <<< 1);
        pa = (da < 0) ? 11'(-da) : 11'(da);
        pb = (db < 0) ? 11'(-db) : 11'(db);
        pc = (dc < 0) ? 11'(-dc) : 11'(dc);
        if (pa <= pb && pa <= pc) begin
            paeth_pred = a;
        end else if (pb <= pc) begin
            paeth_pred = b;
        end else begin
            paeth_pred = c;
        end
    endfunction

endpackage

// ----- hw/rtl/pru_if.sv -----
// Stream interfaces for filtered input bytes and reconstructed output bytes.
interface pru_in_if import pru_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              image_start;

    modport source (output valid, output in_byte, output image_start, input ready);
    modport sink   (input valid, input in_byte, input image_start, output ready);
endinterface

interface pru_out_if import pru_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] pixel_byte;
    logic              row_end;
    logic              bad_type;

    modport source (output valid, output pixel_byte, output row_end, output bad_type,
                     input ready);
    modport sink   (input valid, input pixel_byte, input row_end, input bad_type,
                     output ready);
endinterface

// ----- hw/rtl/png_row_unfilter_top.sv -----
// PNG row unfilter top level: config registers, row store and datapath.
//
// Usage: filtered bytes enter on i_in, one per transfer. Each row is a
// filter-type byte followed by row_length data bytes; image_start marks
// the first byte of an image, which is taken as a type byte and makes the
// following row read zero from above. Every data byte gives one transfer
// on o_out with the reconstructed byte, row_end on the last byte of a row
// and bad_type when the row's code was above 4 (handled as None). Type
// bytes give no output transfer.
// Throughput: one byte per cycle while o_out does not stall. Each data
// byte is registered in the reconstruction stage, then in the output
// register that drives o_out; the reconstruction loop (left neighbor ->
// predictor -> add -> history register) closes within that stage; the row
// store's registered read port is addressed at input transfer time.
// Reset (synchronous, active low) clears row state and pipeline valids and
// sets row_length and bytes_per_pixel to 1; the row store needs no clear.
// When o_out stalls, input bytes are still taken until a data byte waits
// in the reconstruction stage, then i_in.ready drops until o_out.ready.
// Registers (APB): 0x0 row_length, 0x4 bytes_per_pixel; write while idle.
module png_row_unfilter_top import pru_pkg::*; #(
    parameter int MAX_ROW_BYTES = DEF_MAX_ROW_BYTES,
    parameter int MAX_BPP       = DEF_MAX_BPP
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pru_in_if.sink            i_in,
    pru_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int POS_W = $clog2(MAX_ROW_BYTES);

    t_cfg              w_cfg;
    logic              w_ram_we;
    logic [POS_W-1:0]  w_ram_waddr;
    logic [BYTE_W-1:0] w_ram_wdata;
    logic              w_ram_re;
    logic [POS_W-1:0]  w_ram_raddr;
    logic [BYTE_W-1:0] w_ram_rdata;

    pru_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pru_above_ram #(
        .DEPTH (MAX_ROW_BYTES),
        .AW    (POS_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    pru_datapath #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .MAX_BPP       (MAX_BPP),
        .POS_W         (POS_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_re    (w_ram_re),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata)
    );

endmodule

// ----- hw/rtl/pru_cfg_regs.sv -----
// APB configuration registers: row length and bytes per pixel.
module pru_cfg_regs import pru_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [ROW_LEN_W-1:0] r_row_length;
    logic [BPP_W-1:0]     r_bpp;
    logic                 w_wr;
    logic                 w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= ROW_LEN_W'(1);
            r_bpp        <= BPP_W'(1);
        end else if (w_wr) begin
            unique case (w_idx)
                REG_ROW_LENGTH: r_row_length <= pwdata[ROW_LEN_W-1:0];
                REG_BPP:        r_bpp        <= pwdata[BPP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_ROW_LENGTH: prdata = APB_DW'(r_row_length);
            REG_BPP:        prdata = APB_DW'(r_bpp);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.row_length      = r_row_length;
    assign o_cfg.bytes_per_pixel = r_bpp;

endmodule

// ----- hw/rtl/pru_above_ram.sv -----
// Previous-row byte store: one write port, one registered read port.
module pru_above_ram import pru_pkg::*; #(
    parameter int DEPTH = DEF_MAX_ROW_BYTES,
    parameter int AW    = $clog2(DEF_MAX_ROW_BYTES)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [BYTE_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/pru_datapath.sv -----
// Row tracking, filter reconstruction stage and output register.
module pru_datapath import pru_pkg::*; #(
    parameter int MAX_ROW_BYTES = DEF_MAX_ROW_BYTES,
    parameter int MAX_BPP       = DEF_MAX_BPP,
    parameter int POS_W         = $clog2(DEF_MAX_ROW_BYTES)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    pru_in_if.sink            i_in,
    pru_out_if.source         o_out,
    output logic              o_ram_we,
    output logic [POS_W-1:0]  o_ram_waddr,
    output logic [BYTE_W-1:0] o_ram_wdata,
    output logic              o_ram_re,
    output logic [POS_W-1:0]  o_ram_raddr,
    input  logic [BYTE_W-1:0] i_ram_rdata
);

    localparam int COL_W = $clog2(MAX_ROW_BYTES + 1);
    localparam int LEN_W = (COL_W > ROW_LEN_W) ? COL_W : ROW_LEN_W;
    localparam int HIX_W = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;

    // row state
    logic [COL_W-1:0]  r_col;
    logic [FLT_W-1:0]  r_filter;
    logic              r_bad;
    logic              r_av;

    // reconstruction stage
    logic              r_s1_valid;
    logic              r_s1_data;
    logic [BYTE_W-1:0] r_s1_byte;
    logic [POS_W-1:0]  r_s1_pos;
    logic              r_s1_aok;
    logic              r_s1_bok;
    logic              r_s1_last;
    logic [FLT_W-1:0]  r_s1_filter;
    logic              r_s1_bad;

    logic [BYTE_W-1:0] r_left [MAX_BPP];
    logic [BYTE_W-1:0] r_ul   [MAX_BPP];

    // output register
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;
    logic              r_out_bad;

    logic [LEN_W-1:0]  w_len;
    logic [LEN_W-1:0]  w_row;
    logic [BPP_W-1:0]  w_bpp;
    logic [HIX_W-1:0]  w_hix;
    logic              w_acc;
    logic [COL_W-1:0]  w_col;
    logic              w_av;
    logic              w_is_data;
    logic [POS_W-1:0]  w_pos;
    logic              w_last;
    logic              w_aok;
    logic              w_type_bad;
    logic              w_s1_fire;
    logic [BYTE_W-1:0] w_a;
    logic [BYTE_W-1:0] w_b;
    logic [BYTE_W-1:0] w_c;
    logic [BYTE_W:0]   w_sum_ab;
    logic [BYTE_W-1:0] w_pred;
    logic [BYTE_W-1:0] w_val;

    // effective configuration
    assign w_row = LEN_W'(i_cfg.row_length);
    always_comb begin
        if (w_row == '0) begin
            w_len = LEN_W'(1);
        end else if (w_row > LEN_W'(MAX_ROW_BYTES)) begin
            w_len = LEN_W'(MAX_ROW_BYTES);
        end else begin
            w_len = w_row;
        end
        if (i_cfg.bytes_per_pixel == '0) begin
            w_bpp = BPP_W'(1);
        end else if (i_cfg.bytes_per_pixel > BPP_W'(MAX_BPP)) begin
            w_bpp = BPP_W'(MAX_BPP);
        end else begin
            w_bpp = i_cfg.bytes_per_pixel;
        end
    end
    assign w_hix = HIX_W'(w_bpp - BPP_W'(1));

    // accept side
    assign w_s1_fire  = r_s1_valid && (!r_s1_data || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || w_s1_fire;
    assign w_acc      = i_in.valid && i_in.ready;

    assign w_col      = i_in.image_start ? '0 : r_col;
    assign w_av       = i_in.image_start ? 1'b0 : r_av;
    assign w_is_data  = (w_col != '0);
    assign w_pos      = POS_W'(w_col - COL_W'(1));
    assign w_last     = (LEN_W'(w_col) >= w_len);
    assign w_aok      = (LEN_W'(w_pos) >= LEN_W'(w_bpp));
    assign w_type_bad = (i_in.in_byte > BYTE_W'(FLT_PAETH));

    assign o_ram_re    = w_acc && w_is_data;
    assign o_ram_raddr = w_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_filter <= FLT_NONE;
            r_bad    <= 1'b0;
            r_av     <= 1'b0;
        end else if (w_acc) begin
            if (!w_is_data) begin
                r_col    <= COL_W'(1);
                r_filter <= w_type_bad ? FLT_NONE : i_in.in_byte[FLT_W-1:0];
                r_bad    <= w_type_bad;
                r_av     <= w_av;
            end else if (w_last) begin
                r_col <= '0;
                r_av  <= 1'b1;
            end else begin
                r_col <= w_col + COL_W'(1);
                r_av  <= w_av;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_data   <= w_is_data;
            r_s1_byte   <= i_in.in_byte;
            r_s1_pos    <= w_pos;
            r_s1_aok    <= w_aok;
            r_s1_bok    <= w_av;
            r_s1_last   <= w_last;
            r_s1_filter <= r_filter;
            r_s1_bad    <= r_bad;
        end
    end

    // reconstruction
    assign w_a      = r_s1_aok ? r_left[w_hix] : '0;
    assign w_b      = r_s1_bok ? i_ram_rdata : '0;
    assign w_c      = (r_s1_aok && r_s1_bok) ? r_ul[w_hix] : '0;
    assign w_sum_ab = {1'b0, w_a} + {1'b0, w_b};

    always_comb begin
        case (r_s1_filter)
            FLT_SUB:   w_pred = w_a;
            FLT_UP:    w_pred = w_b;
            FLT_AVG:   w_pred = w_sum_ab[BYTE_W:1];
            FLT_PAETH: w_pred = paeth_pred(w_a, w_b, w_c);
            default:   w_pred = '0;
        endcase
    end
    assign w_val = r_s1_byte + w_pred;

    assign o_ram_we    = w_s1_fire && r_s1_data;
    assign o_ram_waddr = r_s1_pos;
    assign o_ram_wdata = w_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_BPP; k++) begin
                r_left[k] <= '0;
                r_ul[k]   <= '0;
            end
        end else if (w_s1_fire) begin
            if (r_s1_data) begin
                for (int k = MAX_BPP - 1; k > 0; k--) begin
                    r_left[k] <= r_left[k-1];
                    r_ul[k]   <= r_ul[k-1];
                end
                r_left[0] <= w_val;
                r_ul[0]   <= w_b;
            end else begin
                for (int k = 0; k < MAX_BPP; k++) begin
                    r_left[k] <= '0;
                    r_ul[k]   <= '0;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_fire && r_s1_data) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_fire && r_s1_data) begin
            r_out_byte <= w_val;
            r_out_last <= r_s1_last;
            r_out_bad  <= r_s1_bad;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.pixel_byte = r_out_byte;
    assign o_out.row_end    = r_out_last;
    assign o_out.bad_type   = r_out_bad;

endmodule
